// File: sv/msa_pkg.sv
// shared types and constants for the multi sensor aggregator
`timescale 1ns / 1ps
package msa_pkg;
    localparam int MAX_SENSORS = 16;
    localparam int IDX_W = $clog2(MAX_SENSORS);
    localparam int CNT_W = $clog2(MAX_SENSORS + 1);
    localparam int SUM_W = 32 + CNT_W;

    typedef enum logic [2:0] {
        MODE_MIN    = 3'd0,
        MODE_MAX    = 3'd1,
        MODE_SUM    = 3'd2,
        MODE_MEAN   = 3'd3,
        MODE_MEDIAN = 3'd4,
        MODE_RANGE  = 3'd5,
        MODE_RECENT = 3'd6,
        MODE_RECENT_ALT = 3'd7
    } mode_t;

    localparam logic REG_MODE = 1'b0;
    localparam logic REG_USE  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture item, write slot
        logic scan_clr;  // clear scan accumulators
        logic scan_step; // process slot scan_idx in pass one
        logic rank_clr;  // start rank pass for one candidate
        logic rank_step; // process slot in rank pass
        logic rank_end;  // latch rank result
        logic div_init;
        logic div_step;
        logic finish;    // form result
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic recent;
        logic rv;
        logic cnt_zero;
        logic need_div;
        logic need_rank;
        logic two_ranks;
    } status_t;
endpackage

// File: sv/multi_sensor_aggregator.sv
// top level of the multi sensor aggregator
`timescale 1ns / 1ps
// one item is taken at a time. an invalid reading outside most-recent mode ends after the
// decide state, most-recent mode goes straight to the final state; min, max, sum and range
// take one 16-slot scan; mean adds a 37-step restoring divide; median runs one rank count
// per candidate slot, once or twice. the result sits in an output register;
// the next item may be taken while it waits, but that item's result holds in the final
// state until the register is free. slots reset invalid.
module multi_sensor_aggregator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [3:0]         sensor_index,
    input  logic signed [31:0] reading,
    input  logic               reading_valid,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] combined,
    output logic               combined_valid,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [4:0]         cfg_data
);
    import msa_pkg::*;

    logic [2:0] mode_reg;
    logic [4:0] use_reg;
    cmd_t cmd;
    status_t status;
    logic [IDX_W-1:0] scan_idx;
    logic rank_sel;
    logic [5:0] div_bit;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 3'd0;
            use_reg <= 5'd1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_MODE) mode_reg <= cfg_data[2:0];
            else use_reg <= cfg_data;
        end
    end

    msa_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .status(status), .cmd(cmd),
        .scan_idx(scan_idx), .rank_sel(rank_sel), .div_bit(div_bit)
    );

    msa_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .scan_idx(scan_idx), .rank_sel(rank_sel),
        .div_bit(div_bit), .mode_cfg(mode_reg), .use_cfg(use_reg),
        .sensor_index(sensor_index), .reading(reading), .reading_valid(reading_valid),
        .status(status), .combined(combined), .combined_valid(combined_valid)
    );
endmodule

// File: sv/msa_datapath.sv
// datapath: slot storage, scan, rank selection, serial divider, result register
`timescale 1ns / 1ps
module msa_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  msa_pkg::cmd_t         cmd,
    input  logic [msa_pkg::IDX_W-1:0] scan_idx,
    input  logic                  rank_sel,
    input  logic [5:0]            div_bit,
    input  logic [2:0]            mode_cfg,
    input  logic [4:0]            use_cfg,
    input  logic [3:0]            sensor_index,
    input  logic signed [31:0]    reading,
    input  logic                  reading_valid,
    output msa_pkg::status_t      status,
    output logic signed [31:0]    combined,
    output logic                  combined_valid
);
    import msa_pkg::*;

    logic signed [31:0] slot_reg [MAX_SENSORS];
    logic [MAX_SENSORS-1:0] valid_reg;
    logic signed [31:0] rd_reg;
    logic rv_reg;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [31:0] min_reg, max_reg;
    // rank pass: count of values below/equal to candidate
    logic signed [31:0] cand_reg;
    logic [CNT_W-1:0] lt_reg, le_reg;
    logic signed [31:0] sel_reg [2];
    logic [1:0] found_reg;
    logic [SUM_W-1:0] quo_reg, rem_reg;
    logic signed [31:0] res_reg;
    logic resv_reg;

    logic signed [31:0] slot_v;
    logic slot_in;
    logic [CNT_W-1:0] target;
    logic [4:0] use_sat;
    logic [SUM_W-1:0] abs_sum;
    logic [SUM_W-1:0] rem_sh;
    logic signed [32:0] half_sum;
    logic signed [32:0] diff;
    logic signed [31:0] sum_sat;

    assign slot_v = slot_reg[scan_idx];
    assign slot_in = valid_reg[scan_idx] && ({1'b0, scan_idx} < n_reg);
    assign use_sat = (use_cfg > 5'(MAX_SENSORS)) ? 5'(MAX_SENSORS) : use_cfg;
    // median ranks: lower middle (cnt-1)/2 and upper cnt/2
    assign target = rank_sel ? (cnt_reg >> 1) : ((cnt_reg - 1'b1) >> 1);
    assign abs_sum = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign rem_sh = {rem_reg[SUM_W-2:0], abs_sum[div_bit]};
    assign half_sum = (33'(sel_reg[0]) + 33'(sel_reg[1])) >>> 1;
    assign diff = 33'(max_reg) - 33'(min_reg);
    assign sum_sat = (sum_reg > SUM_W'(32'sh7fffffff)) ? 32'sh7fffffff :
                     (sum_reg < -SUM_W'(33'sh080000000)) ? 32'sh80000000 : 32'(sum_reg);

    assign status.recent    = mode_cfg[2] & mode_cfg[1];
    assign status.rv        = rv_reg;
    // includes the slot counted at this edge, so the last scan step is seen
    assign status.cnt_zero  = (cnt_reg == '0) && !(cmd.scan_step && slot_in);
    assign status.need_div  = (mode_t'(mode_cfg) == MODE_MEAN);
    assign status.need_rank = (mode_t'(mode_cfg) == MODE_MEDIAN);
    assign status.two_ranks = ~cnt_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < MAX_SENSORS; i++)
            begin
                slot_reg[i] <= '0;
            end
        end
        else if (cmd.load && ({1'b0, sensor_index} < CNT_W'(MAX_SENSORS)))
        begin
            slot_reg[IDX_W'(sensor_index)] <= reading;
            valid_reg[IDX_W'(sensor_index)] <= reading_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rd_reg <= reading;
            rv_reg <= reading_valid;
            n_reg <= CNT_W'(use_sat);
        end
        if (cmd.scan_clr)
        begin
            cnt_reg <= '0;
            sum_reg <= '0;
            min_reg <= 32'sh7fffffff;
            max_reg <= 32'sh80000000;
            found_reg <= '0;
        end
        else if (cmd.scan_step && slot_in)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            sum_reg <= sum_reg + SUM_W'(slot_v);
            if (slot_v < min_reg) min_reg <= slot_v;
            if (slot_v > max_reg) max_reg <= slot_v;
        end
        if (cmd.rank_clr)
        begin
            cand_reg <= slot_v;
            lt_reg <= '0;
            le_reg <= '0;
        end
        else if (cmd.rank_step && slot_in)
        begin
            if (slot_v < cand_reg) lt_reg <= lt_reg + 1'b1;
            if (slot_v <= cand_reg) le_reg <= le_reg + 1'b1;
        end
        // candidate has the target rank if lt <= target < le
        if (cmd.rank_end && !found_reg[rank_sel] && (lt_reg <= target) && (target < le_reg))
        begin
            sel_reg[rank_sel] <= cand_reg;
            found_reg[rank_sel] <= 1'b1;
        end
        if (cmd.div_init)
        begin
            quo_reg <= '0;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_sh >= SUM_W'(cnt_reg))
            begin
                rem_reg <= rem_sh - SUM_W'(cnt_reg);
                quo_reg[div_bit] <= 1'b1;
            end
            else
            begin
                rem_reg <= rem_sh;
            end
        end
        if (cmd.finish)
        begin
            if (status.recent)
            begin
                res_reg <= rd_reg;
                resv_reg <= rv_reg;
            end
            else if (cnt_reg == '0)
            begin
                res_reg <= '0;
                resv_reg <= 1'b0;
            end
            else
            begin
                resv_reg <= 1'b1;
                unique case (mode_t'(mode_cfg))
                    MODE_MIN:    res_reg <= min_reg;
                    MODE_MAX:    res_reg <= max_reg;
                    MODE_SUM:    res_reg <= sum_sat;
                    MODE_MEAN:   res_reg <= sum_reg[SUM_W-1] ? -32'(quo_reg) : 32'(quo_reg);
                    MODE_MEDIAN: res_reg <= cnt_reg[0] ? sel_reg[0] : 32'(half_sum);
                    MODE_RANGE:  res_reg <= (diff > 33'sh07fffffff) ? 32'sh7fffffff : 32'(diff);
                    default:     res_reg <= rd_reg;
                endcase
            end
        end
    end

    assign combined = res_reg;
    assign combined_valid = resv_reg;
endmodule

// File: sv/msa_ctrl.sv
// controller: sequences scan, rank, divide and output transfer
`timescale 1ns / 1ps
module msa_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  msa_pkg::status_t      status,
    output msa_pkg::cmd_t         cmd,
    output logic [msa_pkg::IDX_W-1:0] scan_idx,
    output logic                  rank_sel,
    output logic [5:0]            div_bit
);
    import msa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_SCAN, S_RCAND, S_RCOUNT, S_RJUDGE, S_DIV, S_FIN
    } state_t;

    state_t state_reg;
    logic [IDX_W-1:0] idx_reg, cand_reg;
    logic sel_reg;
    logic [5:0] bit_reg;
    logic ov_reg;

    logic fin_go;
    assign fin_go = (state_reg == S_FIN) && (!ov_reg || out_ready);
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign scan_idx = (state_reg == S_RCAND) ? cand_reg : idx_reg;
    assign rank_sel = sel_reg;
    assign div_bit = bit_reg;

    always_comb
    begin
        cmd = '0;
        cmd.load = in_valid && in_ready;
        unique case (state_reg)
            S_DECIDE: cmd.scan_clr = 1'b1;
            S_SCAN:   cmd.scan_step = 1'b1;
            S_RCAND:  cmd.rank_clr = 1'b1;
            S_RCOUNT: cmd.rank_step = 1'b1;
            S_RJUDGE: cmd.rank_end = 1'b1;
            S_DIV:    cmd.div_step = 1'b1;
            S_FIN:    cmd.finish = fin_go;
            default:  cmd.div_init = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg <= '0;
            cand_reg <= '0;
            sel_reg <= 1'b0;
            bit_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (fin_go) ov_reg <= 1'b1;
            else if (out_ready) ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid) state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    idx_reg <= '0;
                    if (status.recent) state_reg <= S_FIN;
                    else if (!status.rv) state_reg <= S_IDLE;
                    else state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == IDX_W'(MAX_SENSORS - 1))
                    begin
                        cand_reg <= '0;
                        sel_reg <= 1'b0;
                        bit_reg <= 6'(SUM_W - 1);
                        if (status.cnt_zero) state_reg <= S_FIN;
                        else if (status.need_rank) state_reg <= S_RCAND;
                        else if (status.need_div) state_reg <= S_DIV;
                        else state_reg <= S_FIN;
                    end
                end
                S_RCAND:
                begin
                    idx_reg <= '0;
                    state_reg <= S_RCOUNT;
                end
                S_RCOUNT:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == IDX_W'(MAX_SENSORS - 1)) state_reg <= S_RJUDGE;
                end
                S_RJUDGE:
                begin
                    if (cand_reg == IDX_W'(MAX_SENSORS - 1))
                    begin
                        cand_reg <= '0;
                        if (status.two_ranks && !sel_reg)
                        begin
                            sel_reg <= 1'b1;
                            state_reg <= S_RCAND;
                        end
                        else state_reg <= S_FIN;
                    end
                    else
                    begin
                        cand_reg <= cand_reg + 1'b1;
                        state_reg <= S_RCAND;
                    end
                end
                S_DIV:
                begin
                    bit_reg <= bit_reg - 1'b1;
                    if (bit_reg == '0) state_reg <= S_FIN;
                end
                default:
                begin
                    if (fin_go) state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_noacc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready) else $error("ready while busy");
    a_ovset: assert property (@(posedge clk) disable iff (!rst_n)
        fin_go |=> ov_reg) else $error("result lost");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |=> ov_reg) else $error("result dropped");
`endif
endmodule

// File: tb/multi_sensor_aggregator_tb.sv
// testbench for the multi sensor aggregator: queued driver, monitor and fusion predictor
`timescale 1ns / 1ps
module multi_sensor_aggregator_tb;
    import msa_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000; // longer than a worst-case median plus stalls
    localparam int DRAIN_CYCLES   = 700;   // covers one full median pass
    localparam int NUM_PHASES     = 16;
    localparam int PHASE_ITEMS    = 125;

    typedef struct {
        logic [3:0]         idx;
        logic signed [31:0] rd;
        logic               rv;
    } reading_item_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [3:0]         sensor_index;
    logic signed [31:0] reading;
    logic               reading_valid;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] combined;
    logic               combined_valid;
    logic               cfg_we;
    logic               cfg_index;
    logic [4:0]         cfg_data;

    multi_sensor_aggregator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .sensor_index(sensor_index), .reading(reading), .reading_valid(reading_valid),
        .out_valid(out_valid), .out_ready(out_ready),
        .combined(combined), .combined_valid(combined_valid),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // readings waiting for the driver
    reading_item_t pending_readings[$];
    // expected fused outputs, oldest first
    logic signed [31:0] fused_val_q[$];
    logic               fused_v_q[$];

    // predictor copy of the block state and registers
    logic signed [31:0] slot_rd[MAX_SENSORS];
    logic               slot_ok[MAX_SENSORS];
    logic [2:0]         cur_mode;
    logic [4:0]         cur_use;

    int errors;
    int idle_pct_send;
    int idle_pct_recv;
    int quiet_cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // append one expected result
    function automatic void expect_result(input logic signed [31:0] val, input logic vld);
        fused_val_q = {fused_val_q, val};
        fused_v_q = {fused_v_q, vld};
    endfunction

    // store one reading and queue the fused value it causes, if any
    function automatic void fuse_reading(input reading_item_t it);
        longint vals[MAX_SENSORS];
        longint sum;
        longint v;
        longint res;
        int n;
        int cnt;
        int j;
        sum = 0;
        cnt = 0;
        res = 0;
        slot_rd[it.idx] = it.rd;
        slot_ok[it.idx] = it.rv;
        // most-recent modes (both codes) pass the reading through
        if (cur_mode >= MODE_RECENT)
        begin
            expect_result(it.rd, it.rv);
            return;
        end
        if (!it.rv)
            return;
        n = (cur_use > MAX_SENSORS) ? MAX_SENSORS : int'(cur_use);
        for (int i = 0; i < n; i++)
        begin
            if (slot_ok[i])
            begin
                v = longint'(slot_rd[i]);
                j = cnt;
                while (j > 0 && vals[j - 1] > v)
                begin
                    vals[j] = vals[j - 1];
                    j--;
                end
                vals[j] = v;
                cnt++;
                sum += v;
            end
        end
        // no valid slot in use gives an invalid zero
        if (cnt == 0)
        begin
            expect_result(32'sd0, 1'b0);
            return;
        end
        case (cur_mode)
            MODE_MIN:  res = vals[0];
            MODE_MAX:  res = vals[cnt - 1];
            MODE_SUM:  res = sum;
            MODE_MEAN: res = sum / cnt;
            MODE_MEDIAN:
            begin
                if (cnt % 2 == 1)
                    res = vals[cnt / 2];
                else
                    res = (vals[cnt / 2] + vals[cnt / 2 - 1]) >>> 1;
            end
            default:   res = vals[cnt - 1] - vals[0];
        endcase
        // saturate sum and range
        if (res > 64'sd2147483647)
            res = 64'sd2147483647;
        if (res < -64'sd2147483648)
            res = -64'sd2147483648;
        expect_result(res[31:0], 1'b1);
    endfunction

    // driver: one transfer at a time, random gaps per phase
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            sensor_index  <= '0;
            reading       <= '0;
            reading_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                fuse_reading('{idx: sensor_index, rd: reading, rv: reading_valid});
            // payload only changes once the current transfer is done
            if (!in_valid || in_ready)
            begin
                if (pending_readings.size() != 0 && $urandom_range(99) >= idle_pct_send)
                begin
                    reading_item_t it;
                    it = pending_readings.pop_front();
                    in_valid      <= 1'b1;
                    sensor_index  <= it.idx;
                    reading       <= it.rd;
                    reading_valid <= it.rv;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: random back-pressure, compare against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            out_ready <= ($urandom_range(99) >= idle_pct_recv);
            if (out_valid && out_ready)
            begin
                if (fused_val_q.size() == 0)
                begin
                    $display("%0t: unexpected output combined=%0d valid=%0b",
                             $time, combined, combined_valid);
                    errors++;
                end
                else
                begin
                    logic signed [31:0] ev;
                    logic               evv;
                    ev  = fused_val_q.pop_front();
                    evv = fused_v_q.pop_front();
                    if (combined !== ev)
                    begin
                        $display("%0t: combined expected %0d actual %0d", $time, ev, combined);
                        errors++;
                    end
                    if (combined_valid !== evv)
                    begin
                        $display("%0t: combined_valid expected %0b actual %0b",
                                 $time, evv, combined_valid);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("multi_sensor_aggregator_tb: errors");
            $finish;
        end
    end

    task automatic write_reg(input logic idx, input logic [4:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_MODE)
            cur_mode = val[2:0];
        else
            cur_use = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait for all queued readings and expected outputs, then let the block settle
    task automatic drain();
        while (pending_readings.size() != 0 || in_valid || fused_val_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_reading();
        case ($urandom_range(7))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $signed(32'($urandom_range(200)) - 32'd100);
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic push_reading(input logic [3:0] idx, input logic signed [31:0] rd,
                                input logic rv);
        reading_item_t it;
        it = '{idx: idx, rd: rd, rv: rv};
        pending_readings = {pending_readings, it};
    endtask

    initial
    begin
        logic [4:0] use_val;
        errors        = 0;
        idle_pct_send = 0;
        idle_pct_recv = 0;
        quiet_cycles  = 0;
        cfg_we        = 1'b0;
        cfg_index     = REG_MODE;
        cfg_data      = '0;
        cur_mode      = MODE_MIN;
        cur_use       = 5'd1;
        for (int i = 0; i < MAX_SENSORS; i++)
        begin
            slot_rd[i] = '0;
            slot_ok[i] = 1'b0;
        end
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes in every slot under min, including invalid readings
        write_reg(REG_MODE, 5'(MODE_MIN));
        write_reg(REG_USE, 5'd16);
        push_reading(4'd0, 32'sh7FFFFFFF, 1'b1);
        push_reading(4'd15, 32'sh80000000, 1'b1);
        push_reading(4'd3, 32'sh00010000, 1'b0);
        push_reading(4'd7, 32'shFFFFFFFF, 1'b1);
        push_reading(4'd8, 32'sh00000000, 1'b1);
        for (int i = 1; i < 15; i++)
            push_reading(4'(i), (i % 2) ? 32'sh7FFFFFFF : 32'sh80000000, 1'b1);
        push_reading(4'd15, 32'sh80000000, 1'b0);
        drain();

        // random phases over all modes, varied slot counts and idling patterns
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p % 6)
                0: use_val = 5'd16;
                1: use_val = 5'd0;
                2: use_val = 5'd1;
                3: use_val = 5'd31;
                4: use_val = 5'd2;
                default: use_val = 5'($urandom_range(1, 31));
            endcase
            write_reg(REG_MODE, 5'(p % 8));
            write_reg(REG_USE, use_val);
            case (p % 4)
                0: begin idle_pct_send = 0;  idle_pct_recv = 0;  end
                1: begin idle_pct_send = 78; idle_pct_recv = 0;  end
                2: begin idle_pct_send = 0;  idle_pct_recv = 78; end
                default: begin idle_pct_send = 12; idle_pct_recv = 12; end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++)
                push_reading(4'($urandom_range(15)), pick_reading(),
                             $urandom_range(99) < 80);
            drain();
        end

        if (errors == 0)
            $display("multi_sensor_aggregator_tb: clean");
        else
            $display("multi_sensor_aggregator_tb: errors");
        $finish;
    end
endmodule
